/* hdl/qlfo_pkg.sv */
`default_nettype none
package qlfo_pkg;

    localparam int unsigned FieldW   = 12;
    localparam int unsigned PhaseW   = 32;
    localparam int unsigned EnvW     = 25;
    localparam int unsigned RateW    = 24;
    localparam int unsigned OutW     = 4;
    localparam int unsigned CordW    = 36;

    localparam logic [24:0] EnvOne      = 25'd16777216;
    localparam logic [23:0] RateDefault = 24'd16770438;
    localparam logic [23:0] RateMin     = 24'd1677722;
    localparam logic [11:0] FadeThresh  = 12'd10;
    localparam logic [35:0] CordicGain  = 36'd652032874;

    // Configuration register indexes.
    localparam logic [0:0] RegFadeRate  = 1'b0;
    localparam logic [0:0] RegSpeedMode = 1'b1;

    // Lane sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENV,
        ST_PHASE,
        ST_CORDIC,
        ST_MUL1,
        ST_MUL2,
        ST_DONE
    } lane_state_t;

    // Tick settings shared by all lanes.
    typedef struct packed {
        logic [11:0] speed;
        logic [11:0] spread;
        logic        fade_on;
        logic [11:0] level;
        logic [24:0] mult;
        logic        speed_mode;
    } tick_t;

    // atan(2^-k), a full turn being 2^32.
    function automatic logic [31:0] atan_lut(input logic [4:0] k);
        logic [31:0] v;
        begin
            case (k)
                5'd0:  v = 32'd536870912;
                5'd1:  v = 32'd316933406;
                5'd2:  v = 32'd167458907;
                5'd3:  v = 32'd85004756;
                5'd4:  v = 32'd42667331;
                5'd5:  v = 32'd21354465;
                5'd6:  v = 32'd10679838;
                5'd7:  v = 32'd5340245;
                5'd8:  v = 32'd2670163;
                5'd9:  v = 32'd1335087;
                5'd10: v = 32'd667544;
                5'd11: v = 32'd333772;
                5'd12: v = 32'd166886;
                5'd13: v = 32'd83443;
                5'd14: v = 32'd41722;
                5'd15: v = 32'd20861;
                5'd16: v = 32'd10430;
                5'd17: v = 32'd5215;
                5'd18: v = 32'd2608;
                5'd19: v = 32'd1304;
                5'd20: v = 32'd652;
                5'd21: v = 32'd326;
                5'd22: v = 32'd163;
                5'd23: v = 32'd81;
                5'd24: v = 32'd41;
                5'd25: v = 32'd20;
                5'd26: v = 32'd10;
                5'd27: v = 32'd5;
                5'd28: v = 32'd3;
                5'd29: v = 32'd1;
                5'd30: v = 32'd1;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

/* hdl/qlfo_lane.sv */
`default_nettype none
// One lane: envelope update, phase advance, iterative CORDIC cosine and scaling.
module qlfo_lane #(
    parameter int unsigned STEPS = 20,
    parameter logic [13:0] LANE_IDX = 14'd0
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire qlfo_pkg::tick_t tick,
    input  wire logic           gate,
    output logic                done,
    output logic [11:0]         wave
);
    localparam int unsigned KW = (STEPS > 1) ? $clog2(STEPS) : 1;

    qlfo_pkg::lane_state_t state_reg, state_next;
    logic [31:0] phase_reg;
    logic [24:0] env_reg;
    logic [11:0] speed_reg, speed_next;
    logic [KW-1:0] k_reg;
    logic signed [35:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic flip_reg;
    logic [44:0] prod_reg;
    logic [45:0] hi_reg;
    logic [24:0] lo_reg;

    logic [24:0] env_cl, env_new;
    logic [49:0] env_prod;
    logic [36:0] spd_prod;
    logic [31:0] step_add, phase_new, p_rot;
    logic signed [35:0] dx, dy;
    logic [31:0] at;
    logic signed [36:0] c_raw;
    logic [32:0] h;
    logic [45:0] wave_sum;

    // Envelope recurrence.
    always_comb
    begin
        env_cl   = (env_reg > qlfo_pkg::EnvOne) ? qlfo_pkg::EnvOne : env_reg;
        env_prod = (qlfo_pkg::EnvOne - env_cl) * tick.mult;
        if (!tick.fade_on)
            env_new = qlfo_pkg::EnvOne;
        else if (gate)
            env_new = qlfo_pkg::EnvOne - 25'(env_prod >> 24);
        else
            env_new = '0;
        spd_prod = tick.speed * env_reg;
        speed_next = (tick.fade_on && tick.speed_mode) ? 12'(spd_prod >> 24) : tick.speed;
    end

    // Phase advance and quadrant fold.
    always_comb
    begin
        step_add  = (32'(speed_reg) + 32'd20) * 32'd200
                  + 32'(tick.spread) * 32'd3 * 32'(LANE_IDX);
        phase_new = phase_reg + step_add;
        p_rot     = phase_new + 32'h4000_0000;
    end

    // One CORDIC rotation per cycle.
    always_comb
    begin
        dx = y_reg >>> k_reg;
        dy = x_reg >>> k_reg;
        at = qlfo_pkg::atan_lut(5'(k_reg));
        c_raw = flip_reg ? -(37'(x_reg) <<< 1) : (37'(x_reg) <<< 1);
        if (c_raw > 37'sd2147483648)
            h = 33'd4294967296;
        else if (c_raw < -37'sd2147483648)
            h = 33'd0;
        else
            h = 33'(c_raw + 37'sd2147483648);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qlfo_pkg::ST_IDLE:   if (start) state_next = qlfo_pkg::ST_ENV;
            qlfo_pkg::ST_ENV:    state_next = qlfo_pkg::ST_PHASE;
            qlfo_pkg::ST_PHASE:  state_next = qlfo_pkg::ST_CORDIC;
            qlfo_pkg::ST_CORDIC:
                if (32'(k_reg) == STEPS - 1) state_next = qlfo_pkg::ST_MUL1;
            qlfo_pkg::ST_MUL1:   state_next = qlfo_pkg::ST_MUL2;
            qlfo_pkg::ST_MUL2:   state_next = qlfo_pkg::ST_DONE;
            qlfo_pkg::ST_DONE:   state_next = qlfo_pkg::ST_IDLE;
            default:             state_next = qlfo_pkg::ST_IDLE;
        endcase
    end

    // The two partial products of the envelope scaling are summed here and the
    // value holds until the next tick reaches its scaling stage.
    always_comb
    begin
        done     = (state_reg == qlfo_pkg::ST_DONE);
        wave_sum = hi_reg + 46'(lo_reg);
        wave     = 12'(wave_sum >> 32);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qlfo_pkg::ST_IDLE;
            phase_reg <= '0;
            env_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == qlfo_pkg::ST_IDLE && start)
                env_reg <= env_new;
            if (state_reg == qlfo_pkg::ST_PHASE)
                phase_reg <= phase_new;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            qlfo_pkg::ST_ENV:
                speed_reg <= speed_next;
            qlfo_pkg::ST_PHASE:
            begin
                flip_reg <= p_rot[31];
                z_reg    <= 34'(signed'(p_rot[31] ? phase_new + 32'h8000_0000 : phase_new));
                x_reg    <= qlfo_pkg::CordicGain;
                y_reg    <= '0;
                k_reg    <= '0;
            end
            qlfo_pkg::ST_CORDIC:
            begin
                if (!z_reg[33])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - 34'(at);
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + 34'(at);
                end
                k_reg <= k_reg + 1'b1;
            end
            qlfo_pkg::ST_MUL1:
                prod_reg <= 45'(h) * 45'(tick.level);
            qlfo_pkg::ST_MUL2:
            begin
                // Envelope scaling split at bit 24 of the product.
                hi_reg <= 46'(prod_reg[44:24]) * 46'(env_reg);
                lo_reg <= 25'((49'(prod_reg[23:0]) * 49'(env_reg)) >> 24);
            end
            default: ;
        endcase
    end

    property p_env_bound;
        @(posedge clk) disable iff (!rst_n) env_reg <= qlfo_pkg::EnvOne;
    endproperty
    a_env_bound: assert property (p_env_bound) else $error("envelope above one");

    property p_done_pulse;
        @(posedge clk) disable iff (!rst_n) done |=> !done;
    endproperty
    a_done_pulse: assert property (p_done_pulse) else $error("done held");

    property p_start_idle;
        @(posedge clk) disable iff (!rst_n)
            (start && state_reg == qlfo_pkg::ST_IDLE) |=> state_reg == qlfo_pkg::ST_ENV;
    endproperty
    a_start_idle: assert property (p_start_idle) else $error("lane did not start");
endmodule
`default_nettype wire

/* hdl/quad_cosine_lfo_with_fade_in.sv */
// Four-lane cosine LFO with gated fade-in. Each input beat is one tick and yields
// one output beat carrying all lane values. Lanes run in parallel; each tick passes
// through tick capture and fade multiplier forming, then envelope, phase, one CORDIC
// rotation per cycle, two scaling states and a done state. A new tick is taken only
// after the result of the last one has moved into the output register. A stalled
// output register holds the lane results and the input until it frees.
`default_nettype none
module quad_cosine_lfo_with_fade_in #(
    parameter int unsigned LANES        = 4,
    parameter int unsigned CORDIC_STEPS = 20
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // speed_amount, spread_amount, fade_amount, out_level, gate_bits
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // wave_out0, wave_out1, wave_out2, wave_out3
    output logic [47:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);
    logic [23:0] rate_reg;
    logic        mode_reg;
    logic        busy_reg;
    logic        pend_reg;
    logic        m_valid_reg;
    logic [47:0] m_data_reg;
    qlfo_pkg::tick_t tick_reg;
    logic [LANES-1:0] gate_reg;
    logic [LANES-1:0] done_w;
    logic [11:0] wave_w [LANES];
    logic        start;
    logic        start_d;
    logic        load_out;
    logic [36:0] mprod;
    logic [47:0] packed_out;

    assign s_tready = !busy_reg;
    assign start    = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign mprod    = (25'(qlfo_pkg::EnvOne) - 25'(rate_reg)) * s_tdata[35:24];
    assign load_out = (done_w[0] || pend_reg) && (!m_valid_reg || m_tready);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= qlfo_pkg::RateDefault;
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                qlfo_pkg::RegFadeRate:
                    rate_reg <= (cfg_data < qlfo_pkg::RateMin) ? qlfo_pkg::RateDefault
                                                               : cfg_data;
                qlfo_pkg::RegSpeedMode: mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Tick capture.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            tick_reg.speed      <= s_tdata[11:0];
            tick_reg.spread     <= s_tdata[23:12];
            tick_reg.fade_on    <= s_tdata[35:24] > qlfo_pkg::FadeThresh;
            tick_reg.level      <= s_tdata[47:36];
            tick_reg.mult       <= 25'(rate_reg) + 25'(mprod >> 12);
            tick_reg.speed_mode <= mode_reg;
            for (int i = 0; i < LANES; i++)
                gate_reg[i] <= (i < 4) ? s_tdata[48+i] : 1'b0;
        end
    end

    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_lane
            qlfo_lane #(.STEPS(CORDIC_STEPS), .LANE_IDX(14'(g))) u_lane (
                .clk(clk), .rst_n(rst_n), .start(busy_reg && !done_w[0] && start_d),
                .tick(tick_reg), .gate(gate_reg[g]), .done(done_w[g]), .wave(wave_w[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_d <= 1'b0;
        else
            start_d <= start;
    end

    // Merge lane results into one output beat.
    always_comb
    begin
        packed_out = '0;
        for (int i = 0; i < LANES && i < qlfo_pkg::OutW; i++)
            packed_out[i*12 +: 12] = wave_w[i];
    end

    // A finished tick waits in the lanes until the output register is free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (start)
                busy_reg <= 1'b1;
            else if (load_out)
                busy_reg <= 1'b0;
            if (load_out)
                pend_reg <= 1'b0;
            else if (done_w[0])
                pend_reg <= 1'b1;
            if (load_out)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            m_data_reg <= packed_out;
    end

    property p_no_start_busy;
        @(posedge clk) disable iff (!rst_n) busy_reg |-> !start;
    endproperty
    a_no_start_busy: assert property (p_no_start_busy) else $error("tick taken while busy");

    property p_lanes_together;
        @(posedge clk) disable iff (!rst_n) done_w[0] |-> (done_w == {LANES{1'b1}});
    endproperty
    a_lanes_together: assert property (p_lanes_together) else $error("lanes out of step");

    property p_done_busy;
        @(posedge clk) disable iff (!rst_n) done_w[0] |-> busy_reg;
    endproperty
    a_done_busy: assert property (p_done_busy) else $error("result without tick");
endmodule
`default_nettype wire
